// ===== rtl/core/moe_topk_softmax_gate_macros.svh =====
// Assertion macros for the top-k softmax gate.
// Needs clk and arst_n in the scope where a macro is used.
`ifndef MOE_TOPK_SOFTMAX_GATE_MACROS_SVH
`define MOE_TOPK_SOFTMAX_GATE_MACROS_SVH
`ifndef SYNTHESIS
`define MTSG_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define MTSG_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define MTSG_ASSERT(lbl, prop, msg)
`define MTSG_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// ===== rtl/core/moe_tk_pkg.sv =====
// Shared types, codes and the exponential table of the top-k softmax gate.
// No dependencies.
package moe_tk_pkg;

	localparam logic [2:0] KIND_HW   = 3'd0;
	localparam logic [2:0] KIND_HB   = 3'd1;
	localparam logic [2:0] KIND_EW   = 3'd2;
	localparam logic [2:0] KIND_EB   = 3'd3;
	localparam logic [2:0] KIND_FEAT = 3'd4;

	localparam logic [1:0] CFG_INPUT_DIM   = 2'd0;
	localparam logic [1:0] CFG_HIDDEN_DIM  = 2'd1;
	localparam logic [1:0] CFG_NUM_EXPERTS = 2'd2;
	localparam logic [1:0] CFG_NUM_ACTIVE  = 2'd3;

	localparam int CFG_W    = 7;
	localparam int ACT_W    = 4;
	localparam int IDX_W    = 8;
	localparam int LOGIT_W  = 24;
	localparam int EXP_W    = 17;
	localparam int EXP_BITS = 12;

	localparam logic [CFG_W-1:0] RST_INPUT_DIM   = 7'd64;
	localparam logic [CFG_W-1:0] RST_HIDDEN_DIM  = 7'd64;
	localparam logic [CFG_W-1:0] RST_NUM_EXPERTS = 7'd64;
	localparam logic [ACT_W-1:0] RST_NUM_ACTIVE  = 4'd2;

	typedef struct packed {
		logic [2:0]         kind;
		logic [5:0]         row;
		logic [5:0]         col;
		logic signed [15:0] value;
	} in_word_t;

	typedef struct packed {
		logic [5:0]  expert_index;
		logic [15:0] gate_weight;
		logic [2:0]  rank;
		logic        last;
	} out_word_t;

	typedef struct packed {
		logic                      we;
		logic [IDX_W-1:0]          addr;
		logic signed [LOGIT_W-1:0] data;
	} logit_wr_t;

	// exp(-2^(i-8)) in Q0.16
	function automatic logic [15:0] exp_bit(input logic [3:0] i);
		logic [15:0] t;
		case (i)
			4'd0:    t = 16'd65280;
			4'd1:    t = 16'd65026;
			4'd2:    t = 16'd64520;
			4'd3:    t = 16'd63520;
			4'd4:    t = 16'd61565;
			4'd5:    t = 16'd57835;
			4'd6:    t = 16'd51039;
			4'd7:    t = 16'd39750;
			4'd8:    t = 16'd24109;
			4'd9:    t = 16'd8869;
			4'd10:   t = 16'd1200;
			4'd11:   t = 16'd22;
			default: t = 16'd0;
		endcase
		return t;
	endfunction

endpackage

// ===== rtl/core/moe_tk_mac.sv =====
// Router datapath: weight, bias, feature and hidden memories with one shared MAC.
// Depends on moe_tk_pkg; sends expert logits to moe_tk_sel.
module moe_tk_mac #(
	parameter int MAX_INPUT   = 64,
	parameter int MAX_HIDDEN  = 64,
	parameter int MAX_EXPERTS = 64
) (
	input  logic                                       clk,
	input  logic                                       arst_n,
	input  logic                                       load,
	input  moe_tk_pkg::in_word_t                       item,
	input  logic [(MAX_INPUT > 1 ? $clog2(MAX_INPUT) : 1)-1:0] feat_addr,
	input  logic                                       start,
	input  logic [$clog2(MAX_INPUT+1)-1:0]             ni,
	input  logic [$clog2(MAX_HIDDEN+1)-1:0]            nh,
	input  logic [$clog2(MAX_EXPERTS+1)-1:0]           ne,
	output moe_tk_pkg::logit_wr_t                      logit_wr,
	output logic                                       done,
	output logic                                       busy
);

	localparam int FCW  = MAX_INPUT > 1 ? $clog2(MAX_INPUT) : 1;
	localparam int HCW  = MAX_HIDDEN > 1 ? $clog2(MAX_HIDDEN) : 1;
	localparam int ECW  = MAX_EXPERTS > 1 ? $clog2(MAX_EXPERTS) : 1;
	localparam int HWD  = MAX_HIDDEN * MAX_INPUT;
	localparam int EWD  = MAX_EXPERTS * MAX_HIDDEN;
	localparam int HWAW = HWD > 1 ? $clog2(HWD) : 1;
	localparam int EWAW = EWD > 1 ? $clog2(EWD) : 1;
	localparam int BW   = HWAW > EWAW ? HWAW : EWAW;
	localparam int MAXD = MAX_INPUT > MAX_HIDDEN ? MAX_INPUT : MAX_HIDDEN;
	localparam int MAXU = MAX_HIDDEN > MAX_EXPERTS ? MAX_HIDDEN : MAX_EXPERTS;
	localparam int TW   = $clog2(MAXD + 1);
	localparam int UW   = MAXU > 1 ? $clog2(MAXU) : 1;
	localparam int AW   = 34 + $clog2(MAXD + 1);
	localparam int LW   = moe_tk_pkg::LOGIT_W;

	localparam logic [2:0] P_IDLE = 3'd0;
	localparam logic [2:0] P_HID  = 3'd1;
	localparam logic [2:0] P_HDR  = 3'd2;
	localparam logic [2:0] P_EXP  = 3'd3;
	localparam logic [2:0] P_EDR  = 3'd4;

	logic signed [15:0] hw_mem [HWD];
	logic signed [15:0] hb_mem [MAX_HIDDEN];
	logic signed [15:0] ew_mem [EWD];
	logic signed [15:0] eb_mem [MAX_EXPERTS];
	logic signed [15:0] ft_mem [MAX_INPUT];
	logic signed [15:0] hv_mem [MAX_HIDDEN];

	logic signed [15:0] hw_rd_q, hb_rd_q, ew_rd_q, eb_rd_q, ft_rd_q, hv_rd_q;

	logic [2:0]    state_q;
	logic [UW-1:0] unit_q;
	logic [TW-1:0] term_q;
	logic [BW-1:0] base_q;
	logic [TW-1:0] tm1;
	logic [BW-1:0] waddr;
	logic          issue, term_last, unit_last, empty;

	logic          v_s1, first_s1, last_s1, ph_s1;
	logic [UW-1:0] unit_s1;
	logic          v_s2, first_s2, last_s2, ph_s2;
	logic [UW-1:0] unit_s2;
	logic signed [31:0] prod_s2;
	logic          fin_s3, ph_s3;
	logic [UW-1:0] unit_s3;
	logic signed [AW-1:0] acc_q;

	logic signed [AW-1:0] acc_sh;
	logic signed [15:0]   hval;
	logic signed [LW-1:0] lval;

	int ld_hw, ld_ew;

	assign ld_hw = int'(item.row) * MAX_INPUT + int'(item.col);
	assign ld_ew = int'(item.row) * MAX_HIDDEN + int'(item.col);

	always_ff @(posedge clk) begin
		if (load) begin
			case (item.kind)
				moe_tk_pkg::KIND_HW: begin
					if (int'(item.row) < MAX_HIDDEN && int'(item.col) < MAX_INPUT)
						hw_mem[HWAW'(ld_hw)] <= item.value;
				end
				moe_tk_pkg::KIND_HB: begin
					if (int'(item.row) < MAX_HIDDEN) hb_mem[HCW'(item.row)] <= item.value;
				end
				moe_tk_pkg::KIND_EW: begin
					if (int'(item.row) < MAX_EXPERTS && int'(item.col) < MAX_HIDDEN)
						ew_mem[EWAW'(ld_ew)] <= item.value;
				end
				moe_tk_pkg::KIND_EB: begin
					if (int'(item.row) < MAX_EXPERTS) eb_mem[ECW'(item.row)] <= item.value;
				end
				moe_tk_pkg::KIND_FEAT: begin
					ft_mem[feat_addr] <= item.value;
				end
				default: ;
			endcase
		end
	end

	assign tm1   = term_q - TW'(1);
	assign waddr = base_q + BW'(tm1);

	always_ff @(posedge clk) begin
		hw_rd_q <= hw_mem[waddr[HWAW-1:0]];
		ew_rd_q <= ew_mem[waddr[EWAW-1:0]];
		hb_rd_q <= hb_mem[HCW'(unit_q)];
		eb_rd_q <= eb_mem[ECW'(unit_q)];
		ft_rd_q <= ft_mem[FCW'(tm1)];
		hv_rd_q <= hv_mem[HCW'(tm1)];
		if (fin_s3 && !ph_s3) hv_mem[HCW'(unit_s3)] <= hval;
	end

	assign issue     = (state_q == P_HID) || (state_q == P_EXP);
	assign term_last = (state_q == P_HID) ? (int'(term_q) == int'(ni))
	                                      : (int'(term_q) == int'(nh));
	assign unit_last = (state_q == P_HID) ? (int'(unit_q) == int'(nh) - 1)
	                                      : (int'(unit_q) == int'(ne) - 1);
	assign empty     = !v_s1 && !v_s2 && !fin_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= P_IDLE;
			unit_q  <= '0;
			term_q  <= '0;
			base_q  <= '0;
		end else begin
			case (state_q)
				P_IDLE: begin
					if (start) begin
						state_q <= P_HID;
						unit_q  <= '0;
						term_q  <= '0;
						base_q  <= '0;
					end
				end
				P_HID, P_EXP: begin
					if (term_last) begin
						term_q <= '0;
						unit_q <= unit_q + UW'(1);
						base_q <= base_q + ((state_q == P_HID) ? BW'(MAX_INPUT) : BW'(MAX_HIDDEN));
						if (unit_last) state_q <= (state_q == P_HID) ? P_HDR : P_EDR;
					end else begin
						term_q <= term_q + TW'(1);
					end
				end
				P_HDR: begin
					if (empty) begin
						state_q <= P_EXP;
						unit_q  <= '0;
						term_q  <= '0;
						base_q  <= '0;
					end
				end
				P_EDR: begin
					if (empty) state_q <= P_IDLE;
				end
				default: state_q <= P_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
			fin_s3 <= 1'b0;
		end else begin
			v_s1   <= issue;
			v_s2   <= v_s1;
			fin_s3 <= v_s2 && last_s2;
		end
	end

	always_ff @(posedge clk) begin
		first_s1 <= (term_q == '0);
		last_s1  <= term_last;
		ph_s1    <= (state_q == P_EXP);
		unit_s1  <= unit_q;

		first_s2 <= first_s1;
		last_s2  <= last_s1;
		ph_s2    <= ph_s1;
		unit_s2  <= unit_s1;
		if (first_s1)
			prod_s2 <= 32'(ph_s1 ? eb_rd_q : hb_rd_q) <<< 8;
		else if (ph_s1)
			prod_s2 <= ew_rd_q * hv_rd_q;
		else
			prod_s2 <= hw_rd_q * ft_rd_q;

		if (v_s2) acc_q <= first_s2 ? AW'(prod_s2) : acc_q + AW'(prod_s2);
		ph_s3   <= ph_s2;
		unit_s3 <= unit_s2;
	end

	assign acc_sh = acc_q >>> 12;

	always_comb begin
		if (acc_q > AW'(0)) begin
			if (acc_sh > AW'(32767)) hval = 16'sd32767;
			else hval = acc_sh[15:0];
		end else begin
			hval = 16'sd0;
		end
		if (acc_sh > AW'(8388607)) lval = 24'sh7FFFFF;
		else if (acc_sh < AW'(-8388608)) lval = 24'sh800000;
		else lval = acc_sh[LW-1:0];
	end

	assign logit_wr.we   = fin_s3 && ph_s3;
	assign logit_wr.addr = moe_tk_pkg::IDX_W'(unit_s3);
	assign logit_wr.data = lval;

	assign done = (state_q == P_EDR) && empty;
	assign busy = (state_q != P_IDLE);

endmodule

// ===== rtl/core/moe_tk_sel.sv =====
// Logit store, max search, table exponential, top-k list and renormalizing divider.
// Depends on moe_tk_pkg and the assertion macros; fed by moe_tk_mac.
`include "moe_topk_softmax_gate_macros.svh"
module moe_tk_sel #(
	parameter int MAX_EXPERTS = 64,
	parameter int MAX_ACTIVE  = 8
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  moe_tk_pkg::logit_wr_t              logit_wr,
	input  logic                               start,
	input  logic [$clog2(MAX_EXPERTS+1)-1:0]   ne,
	input  logic [$clog2(MAX_ACTIVE+1)-1:0]    k,
	output moe_tk_pkg::out_word_t              result,
	output logic                               result_valid,
	input  logic                               result_stall,
	output logic                               busy
);

	localparam int NEW = $clog2(MAX_EXPERTS + 1);
	localparam int KW  = $clog2(MAX_ACTIVE + 1);
	localparam int ECW = MAX_EXPERTS > 1 ? $clog2(MAX_EXPERTS) : 1;
	localparam int RW  = MAX_ACTIVE > 1 ? $clog2(MAX_ACTIVE) : 1;
	localparam int XW  = moe_tk_pkg::EXP_W;
	localparam int SW  = XW + $clog2(MAX_ACTIVE);
	localparam int NW  = XW + 17;
	localparam int DCW = $clog2(NW + 1);
	localparam int LW  = moe_tk_pkg::LOGIT_W;

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_MAX  = 4'd1;
	localparam logic [3:0] S_MXW  = 4'd2;
	localparam logic [3:0] S_ERD  = 4'd3;
	localparam logic [3:0] S_ELD  = 4'd4;
	localparam logic [3:0] S_EIT  = 4'd5;
	localparam logic [3:0] S_INS  = 4'd6;
	localparam logic [3:0] S_SUM  = 4'd7;
	localparam logic [3:0] S_DVI  = 4'd8;
	localparam logic [3:0] S_DIV  = 4'd9;
	localparam logic [3:0] S_EMIT = 4'd10;

	logic signed [LW-1:0] lm_mem [MAX_EXPERTS];
	logic signed [LW-1:0] rd_q;

	logic [3:0]     state_q;
	logic [ECW-1:0] cnt_q;
	logic           rv_q, rfirst_q, rlast_q;
	logic signed [LW-1:0] mx_q;
	logic [XW-1:0]  ex_q;
	logic [11:0]    d_q;
	logic [3:0]     bit_q;
	logic [XW-1:0]  lv_q [MAX_ACTIVE];
	logic [ECW-1:0] li_q [MAX_ACTIVE];
	logic [KW-1:0]  n_q;
	logic [RW-1:0]  r_q;
	logic [SW-1:0]  sum_q;
	logic [NW-1:0]  num_q;
	logic [SW-1:0]  rem_q;
	logic [XW-1:0]  q_q;
	logic [DCW-1:0] dc_q;
	logic           ov_q;
	moe_tk_pkg::out_word_t res_q;

	logic               cnt_last, r_last, emit_go, emit_fire;
	logic signed [LW:0] d;
	logic [33:0]        eprod;
	logic [MAX_ACTIVE-1:0] ge;
	logic [SW:0]        remsh;
	logic               qbit;

	always_ff @(posedge clk) begin
		if (logit_wr.we) lm_mem[ECW'(logit_wr.addr)] <= logit_wr.data;
		rd_q <= lm_mem[cnt_q];
	end

	assign cnt_last  = (NEW'(cnt_q) == ne - NEW'(1));
	assign r_last    = (KW'(r_q) == k - KW'(1));
	assign emit_go   = !ov_q || !result_stall;
	assign emit_fire = (state_q == S_EMIT) && emit_go;
	assign d         = {mx_q[LW-1], mx_q} - {rd_q[LW-1], rd_q};
	assign eprod     = 34'(ex_q) * 34'(moe_tk_pkg::exp_bit(bit_q)) + 34'd32768;
	assign remsh     = {rem_q, num_q[NW-1]};
	assign qbit      = (remsh >= (SW+1)'(sum_q));

	always_comb begin
		for (int j = 0; j < MAX_ACTIVE; j++)
			ge[j] = (j < int'(n_q)) && (lv_q[j] >= ex_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
			rv_q    <= 1'b0;
			n_q     <= '0;
			r_q     <= '0;
			dc_q    <= '0;
			bit_q   <= '0;
			ov_q    <= 1'b0;
		end else begin
			rv_q <= (state_q == S_MAX);
			if (emit_fire) ov_q <= 1'b1;
			else if (!result_stall) ov_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (start) begin
						state_q <= S_MAX;
						cnt_q   <= '0;
						n_q     <= '0;
					end
				end
				S_MAX: begin
					if (cnt_last) begin
						state_q <= S_MXW;
						cnt_q   <= '0;
					end else begin
						cnt_q <= cnt_q + ECW'(1);
					end
				end
				S_MXW: begin
					if (rv_q && rlast_q) state_q <= S_ERD;
				end
				S_ERD: state_q <= S_ELD;
				S_ELD: begin
					bit_q <= '0;
					state_q <= (d[LW:12] != '0) ? S_INS : S_EIT;
				end
				S_EIT: begin
					bit_q <= bit_q + 4'd1;
					if (bit_q == 4'(moe_tk_pkg::EXP_BITS - 1)) state_q <= S_INS;
				end
				S_INS: begin
					if (n_q < k) n_q <= n_q + KW'(1);
					if (cnt_last) begin
						state_q <= S_SUM;
						r_q     <= '0;
					end else begin
						cnt_q   <= cnt_q + ECW'(1);
						state_q <= S_ERD;
					end
				end
				S_SUM: begin
					if (r_last) begin
						state_q <= S_DVI;
						r_q     <= '0;
					end else begin
						r_q <= r_q + RW'(1);
					end
				end
				S_DVI: begin
					dc_q    <= '0;
					state_q <= S_DIV;
				end
				S_DIV: begin
					dc_q <= dc_q + DCW'(1);
					if (dc_q == DCW'(NW - 1)) state_q <= S_EMIT;
				end
				S_EMIT: begin
					if (emit_go) begin
						if (r_last) begin
							state_q <= S_IDLE;
						end else begin
							r_q     <= r_q + RW'(1);
							state_q <= S_DVI;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		rfirst_q <= (cnt_q == '0);
		rlast_q  <= cnt_last;
		if (rv_q) mx_q <= (rfirst_q || rd_q > mx_q) ? rd_q : mx_q;

		case (state_q)
			S_ELD: begin
				ex_q <= (d[LW:12] != '0) ? '0 : XW'(65536);
				d_q  <= d[11:0];
			end
			S_EIT: begin
				if (d_q[0]) ex_q <= XW'(eprod >> 16);
				d_q <= d_q >> 1;
			end
			S_INS: begin
				for (int j = 0; j < MAX_ACTIVE; j++) begin
					if (!ge[j]) begin
						if (j == 0 || ge[(j == 0) ? 0 : j - 1]) begin
							lv_q[j] <= ex_q;
							li_q[j] <= cnt_q;
						end else begin
							lv_q[j] <= lv_q[(j == 0) ? 0 : j - 1];
							li_q[j] <= li_q[(j == 0) ? 0 : j - 1];
						end
					end
				end
			end
			S_SUM: begin
				sum_q <= ((r_q == '0) ? '0 : sum_q) + SW'(lv_q[r_q]);
			end
			S_DVI: begin
				num_q <= {lv_q[r_q], 16'd0} + NW'(sum_q >> 1);
				rem_q <= '0;
				q_q   <= '0;
			end
			S_DIV: begin
				rem_q <= qbit ? SW'(remsh - (SW+1)'(sum_q)) : SW'(remsh);
				num_q <= num_q << 1;
				q_q   <= {q_q[XW-2:0], qbit};
			end
			S_EMIT: begin
				if (emit_go) begin
					res_q.expert_index <= 6'(li_q[r_q]);
					res_q.gate_weight  <= q_q[XW-1] ? 16'hFFFF : q_q[15:0];
					res_q.rank         <= 3'(r_q);
					res_q.last         <= r_last;
				end
			end
			default: ;
		endcase
	end

	assign result       = res_q;
	assign result_valid = ov_q;
	assign busy         = (state_q != S_IDLE);

	`MTSG_ASSERT(a_fill_within_k, (state_q != S_IDLE) |-> (n_q <= k), "top-k list overfilled")
	`MTSG_ASSERT(a_sum_nonzero, (state_q == S_DIV) |-> (sum_q != '0), "divide by zero sum")
	`MTSG_ASSERT(a_quot_range, (state_q == S_EMIT) |-> (q_q <= XW'(65536)), "gate quotient range")

endmodule

// ===== rtl/core/moe_topk_softmax_gate.sv =====
// Top-k softmax gate for a mixture of experts. Load words (kinds 0..3) are accepted while
// idle. A feature word that completes a token runs the router on a single MAC fed one weight
// or bias word per cycle from its memories; an expert whose exponential underflows skips the
// table steps, and a result word may wait on result_stall. item_stall is high throughout.
// Results are sent best first, one word per chosen expert. Depends on moe_tk_pkg, moe_tk_mac
// and moe_tk_sel.
`include "moe_topk_softmax_gate_macros.svh"
module moe_topk_softmax_gate #(
	parameter int MAX_INPUT   = 64,
	parameter int MAX_HIDDEN  = 64,
	parameter int MAX_EXPERTS = 64,
	parameter int MAX_ACTIVE  = 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  item_valid,
	output logic                  item_stall,
	input  moe_tk_pkg::in_word_t  item,
	output logic                  result_valid,
	input  logic                  result_stall,
	output moe_tk_pkg::out_word_t result,
	input  logic                  cfg_we,
	input  logic [1:0]            cfg_idx,
	input  logic [6:0]            cfg_data
);

	localparam int FCW = MAX_INPUT > 1 ? $clog2(MAX_INPUT) : 1;
	localparam int NIW = $clog2(MAX_INPUT + 1);
	localparam int NHW = $clog2(MAX_HIDDEN + 1);
	localparam int NEW = $clog2(MAX_EXPERTS + 1);
	localparam int KW  = $clog2(MAX_ACTIVE + 1);

	logic [moe_tk_pkg::CFG_W-1:0] idim_q, hdim_q, nexp_q;
	logic [moe_tk_pkg::ACT_W-1:0] nact_q;
	logic [FCW-1:0] fcnt_q;
	logic [FCW:0]   fnext;
	logic [NIW-1:0] ni;
	logic [NHW-1:0] nh;
	logic [NEW-1:0] ne;
	logic [KW-1:0]  ka, k;
	logic           accept, fire, mac_done, mac_busy, sel_busy;
	moe_tk_pkg::logit_wr_t logit_wr;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idim_q <= moe_tk_pkg::RST_INPUT_DIM;
			hdim_q <= moe_tk_pkg::RST_HIDDEN_DIM;
			nexp_q <= moe_tk_pkg::RST_NUM_EXPERTS;
			nact_q <= moe_tk_pkg::RST_NUM_ACTIVE;
		end else if (cfg_we) begin
			case (cfg_idx)
				moe_tk_pkg::CFG_INPUT_DIM:   idim_q <= cfg_data;
				moe_tk_pkg::CFG_HIDDEN_DIM:  hdim_q <= cfg_data;
				moe_tk_pkg::CFG_NUM_EXPERTS: nexp_q <= cfg_data;
				moe_tk_pkg::CFG_NUM_ACTIVE:  nact_q <= cfg_data[moe_tk_pkg::ACT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		if (idim_q == '0) ni = NIW'(1);
		else if (int'(idim_q) > MAX_INPUT) ni = NIW'(MAX_INPUT);
		else ni = NIW'(idim_q);
		if (hdim_q == '0) nh = NHW'(1);
		else if (int'(hdim_q) > MAX_HIDDEN) nh = NHW'(MAX_HIDDEN);
		else nh = NHW'(hdim_q);
		if (nexp_q == '0) ne = NEW'(1);
		else if (int'(nexp_q) > MAX_EXPERTS) ne = NEW'(MAX_EXPERTS);
		else ne = NEW'(nexp_q);
		if (nact_q == '0) ka = KW'(1);
		else if (int'(nact_q) > MAX_ACTIVE) ka = KW'(MAX_ACTIVE);
		else ka = KW'(nact_q);
		k = (int'(ka) > int'(ne)) ? KW'(ne) : ka;
	end

	assign item_stall = mac_busy || sel_busy;
	assign accept     = item_valid && !item_stall;
	assign fnext      = {1'b0, fcnt_q} + (FCW+1)'(1);
	assign fire       = accept && (item.kind == moe_tk_pkg::KIND_FEAT)
	                    && (int'(fnext) >= int'(ni));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fcnt_q <= '0;
		end else if (accept && item.kind == moe_tk_pkg::KIND_FEAT) begin
			fcnt_q <= fire ? '0 : fnext[FCW-1:0];
		end
	end

	moe_tk_mac #(
		.MAX_INPUT   (MAX_INPUT),
		.MAX_HIDDEN  (MAX_HIDDEN),
		.MAX_EXPERTS (MAX_EXPERTS)
	) u_mac (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (accept),
		.item      (item),
		.feat_addr (fcnt_q),
		.start     (fire),
		.ni        (ni),
		.nh        (nh),
		.ne        (ne),
		.logit_wr  (logit_wr),
		.done      (mac_done),
		.busy      (mac_busy)
	);

	moe_tk_sel #(
		.MAX_EXPERTS (MAX_EXPERTS),
		.MAX_ACTIVE  (MAX_ACTIVE)
	) u_sel (
		.clk          (clk),
		.arst_n       (arst_n),
		.logit_wr     (logit_wr),
		.start        (mac_done),
		.ne           (ne),
		.k            (k),
		.result       (result),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.busy         (sel_busy)
	);

	`MTSG_ASSERT(a_one_phase, !(mac_busy && sel_busy), "router and selector both busy")

endmodule
